@@ rtl/core/cst_pkg.sv @@
// cst_pkg: shared widths, register codes, reset values and the control
// structs between the window walk and the distance unit
// no dependencies
`timescale 1ns / 1ps

package cst_pkg;

  // parameter defaults
  localparam int unsigned WINDOW_MAX_DEF = 16;
  localparam int unsigned COORD_BITS_DEF = 12;

  // fixed field widths
  localparam int unsigned BOX_W      = 12;
  localparam int unsigned SHARP_W    = 32;
  localparam int unsigned FRAC_W     = 17;
  localparam int unsigned MOVE_W     = 25;
  localparam int unsigned WLEN_W     = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LEN    = 3'd0,
    REG_MOVE_LIM_SQ   = 3'd1,
    REG_SHARP_FLOOR   = 3'd2,
    REG_MAX_CLIP_LOW  = 3'd3,
    REG_MAX_CLIP_HIGH = 3'd4,
    REG_COV_FLOOR     = 3'd5,
    REG_MIN_BOX_WIDTH = 3'd6
  } cfg_reg_e;

  // register reset values
  localparam logic [WLEN_W-1:0]  RST_WINDOW_LEN    = 5'd5;
  localparam logic [MOVE_W-1:0]  RST_MOVE_LIM_SQ   = 25'd400;
  localparam logic [SHARP_W-1:0] RST_SHARP_FLOOR   = 32'd25600;
  localparam logic [FRAC_W-1:0]  RST_MAX_CLIP_LOW  = 17'd3277;
  localparam logic [FRAC_W-1:0]  RST_MAX_CLIP_HIGH = 17'd3277;
  localparam logic [FRAC_W-1:0]  RST_COV_FLOOR     = 17'd62259;
  localparam logic [BOX_W-1:0]   RST_MIN_BOX_WIDTH = 12'd0;

  // one entry issued to the distance unit
  typedef struct packed {
    logic valid;
    logic check;
  } dist_ctl_t;

  // distance unit verdict
  typedef struct packed {
    logic valid;
    logic over;
  } dist_res_t;

endpackage

@@ rtl/core/cst_cell.sv @@
// cst_cell: one stage of the frame window ring, holds one packed entry
// (corners and quality-and-size flag) and passes it on when shifted
// depends on nothing
`timescale 1ns / 1ps

module cst_cell #(
  parameter int unsigned ENTRY_W = 53
) (
  input  logic               clk_i,
  input  logic               shift_i,
  input  logic [ENTRY_W-1:0] d_i,
  output logic [ENTRY_W-1:0] q_o
);

  logic [ENTRY_W-1:0] entry_q;
  logic [ENTRY_W-1:0] entry_d;

  // take the neighbor's entry on a shift, else hold
  always_comb begin
    entry_d = shift_i ? d_i : entry_q;
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign q_o = entry_q;

endmodule

@@ rtl/core/cst_dist.sv @@
// cst_dist: pipelined corner distance check, absolute differences, squares,
// then sums against the move limit
// depends on cst_pkg
`timescale 1ns / 1ps

module cst_dist #(
  parameter int unsigned COORD_BITS = cst_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  cst_pkg::dist_ctl_t                   ctl_i,
  input  logic [4*(COORD_BITS+1)-1:0]          ent_i,
  input  logic [4*(COORD_BITS+1)-1:0]          ref_i,
  input  logic [cst_pkg::MOVE_W-1:0]           move_lim_sq_i,
  output cst_pkg::dist_res_t                   res_o
);

  import cst_pkg::*;

  localparam int unsigned CW    = COORD_BITS + 1;
  localparam int unsigned SQ_W  = 2 * CW;
  localparam int unsigned SUM_W = SQ_W + 1;
  localparam int unsigned CMP_W = (SUM_W > MOVE_W) ? SUM_W : MOVE_W;

  logic [CW-1:0]   diff_d [4];
  logic [CW-1:0]   diff_q [4];
  logic [SQ_W-1:0] sq_d   [4];
  logic [SQ_W-1:0] sq_q   [4];
  logic            a_valid_q;
  logic            a_valid_d;
  logic            b_valid_q;
  logic            b_valid_d;
  logic [SUM_W-1:0] sum_tl;
  logic [SUM_W-1:0] sum_br;

  // absolute difference per coordinate, order x0 y0 x1 y1
  always_comb begin
    logic [CW-1:0] a;
    logic [CW-1:0] b;
    for (int k = 0; k < 4; k++) begin
      a = ent_i[(3-k)*CW +: CW];
      b = ref_i[(3-k)*CW +: CW];
      diff_d[k] = (a >= b) ? (a - b) : (b - a);
    end
  end

  // squares of the registered differences
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sq_d[k] = SQ_W'(diff_q[k]) * SQ_W'(diff_q[k]);
    end
  end

  assign a_valid_d = ctl_i.valid & ctl_i.check;
  assign b_valid_d = a_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    sq_q   <= sq_d;
  end

  // squared distance per corner against the limit
  assign sum_tl = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]);
  assign sum_br = SUM_W'(sq_q[2]) + SUM_W'(sq_q[3]);

  always_comb begin
    res_o.valid = b_valid_q;
    res_o.over  = (CMP_W'(sum_tl) > CMP_W'(move_lim_sq_i)) ||
                  (CMP_W'(sum_br) > CMP_W'(move_lim_sq_i));
  end

endmodule

@@ rtl/core/capture_stability_trigger_unit.sv @@
// capture_stability_trigger_unit: per-frame capture decision over a window
// of recent region boxes; uses cst_pkg, cst_cell and cst_dist
//
// channel  direction  transfer                      payload
// in       input      in_valid_i & in_ready_o       region_found_i .. coverage_i
// out      output     out_valid_o & out_ready_i     qual_pass_o .. capture_fire_o
// cfg      input      cfg_we_i, every asserted edge cfg_index_i, cfg_wdata_i
//
// a record with a region: after the accept, the ring of WINDOW_MAX cells
// is rotated once past a single distance unit, one cell a cycle, then the
// distance pipeline drains and the result is written to the output
// register. a record without a region goes from the accept straight to the
// result. reset empties the window and loads the register defaults; cell
// contents are not cleared. a stalled result sits in the output register
// while the next record is taken; the block then waits in its result state
// until the output register is free.
`timescale 1ns / 1ps

module capture_stability_trigger_unit #(
  parameter int unsigned WINDOW_MAX = cst_pkg::WINDOW_MAX_DEF,
  parameter int unsigned COORD_BITS = cst_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [cst_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cst_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // probe record
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             region_found_i,
  input  logic [cst_pkg::BOX_W-1:0]        box_left_i,
  input  logic [cst_pkg::BOX_W-1:0]        box_top_i,
  input  logic [cst_pkg::BOX_W-1:0]        box_width_i,
  input  logic [cst_pkg::BOX_W-1:0]        box_height_i,
  input  logic [cst_pkg::SHARP_W-1:0]      sharpness_i,
  input  logic [cst_pkg::FRAC_W-1:0]       clip_low_frac_i,
  input  logic [cst_pkg::FRAC_W-1:0]       clip_high_frac_i,
  input  logic [cst_pkg::FRAC_W-1:0]       coverage_i,
  // decision
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             qual_pass_o,
  output logic                             size_ok_o,
  output logic                             stable_o,
  output logic                             capture_fire_o
);

  import cst_pkg::*;

  localparam int unsigned CW      = COORD_BITS + 1;
  localparam int unsigned CORN_W  = 4 * CW;
  localparam int unsigned ENTRY_W = CORN_W + 1;
  localparam int unsigned IDX_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned LEN_W   = $clog2(WINDOW_MAX + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  // configuration registers
  logic [WLEN_W-1:0]  window_len_q;
  logic [MOVE_W-1:0]  move_lim_sq_q;
  logic [SHARP_W-1:0] sharp_floor_q;
  logic [FRAC_W-1:0]  max_clip_low_q;
  logic [FRAC_W-1:0]  max_clip_high_q;
  logic [FRAC_W-1:0]  cov_floor_q;
  logic [BOX_W-1:0]   min_box_width_q;

  // control and payload state
  state_e             state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               drain_q, drain_d;
  logic               fail_q, fail_d;
  logic               ok_all_q, ok_all_d;
  logic               full_q, full_d;
  logic [LEN_W-1:0]   fill_q, fill_d;
  logic               qual_q, qual_d;
  logic               size_q, size_d;
  logic [CORN_W-1:0]  ref_q, ref_d;
  logic               out_valid_q, out_valid_d;
  logic               out_qual_q, out_qual_d;
  logic               out_size_q, out_size_d;
  logic               out_stable_q, out_stable_d;
  logic               out_capture_q, out_capture_d;

  // window ring
  logic [ENTRY_W-1:0] cell_q [WINDOW_MAX];
  logic [ENTRY_W-1:0] cell0_d;
  logic [ENTRY_W-1:0] tail;
  logic [ENTRY_W-1:0] new_entry;
  logic               append;
  logic               walk;

  // helpers
  logic [LEN_W-1:0]   len_eff;
  logic [LEN_W:0]     fill_inc;
  logic [LEN_W:0]     idx_inc;
  logic               quality;
  logic               size_ok;
  logic               in_window;
  logic               is_ref;
  logic               check;
  logic [COORD_BITS-1:0] left_c, top_c, width_c, height_c;
  dist_ctl_t          dist_ctl;
  dist_res_t          dist_res;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q    <= RST_WINDOW_LEN;
      move_lim_sq_q   <= RST_MOVE_LIM_SQ;
      sharp_floor_q   <= RST_SHARP_FLOOR;
      max_clip_low_q  <= RST_MAX_CLIP_LOW;
      max_clip_high_q <= RST_MAX_CLIP_HIGH;
      cov_floor_q     <= RST_COV_FLOOR;
      min_box_width_q <= RST_MIN_BOX_WIDTH;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_LEN:    window_len_q    <= cfg_wdata_i[WLEN_W-1:0];
        REG_MOVE_LIM_SQ:   move_lim_sq_q   <= cfg_wdata_i[MOVE_W-1:0];
        REG_SHARP_FLOOR:   sharp_floor_q   <= cfg_wdata_i[SHARP_W-1:0];
        REG_MAX_CLIP_LOW:  max_clip_low_q  <= cfg_wdata_i[FRAC_W-1:0];
        REG_MAX_CLIP_HIGH: max_clip_high_q <= cfg_wdata_i[FRAC_W-1:0];
        REG_COV_FLOOR:     cov_floor_q     <= cfg_wdata_i[FRAC_W-1:0];
        REG_MIN_BOX_WIDTH: min_box_width_q <= cfg_wdata_i[BOX_W-1:0];
        default: ;
      endcase
    end
  end

  // effective window length, zero acts as one, clamped to the ring size
  always_comb begin
    if (window_len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(window_len_q) > 32'(WINDOW_MAX)) begin
      len_eff = LEN_W'(WINDOW_MAX);
    end else begin
      len_eff = LEN_W'(window_len_q);
    end
  end

  // frame checks and the new window entry
  assign left_c   = COORD_BITS'(box_left_i);
  assign top_c    = COORD_BITS'(box_top_i);
  assign width_c  = COORD_BITS'(box_width_i);
  assign height_c = COORD_BITS'(box_height_i);

  assign quality = (sharpness_i >= sharp_floor_q) &&
                   (clip_low_frac_i <= max_clip_low_q) &&
                   (clip_high_frac_i <= max_clip_high_q) &&
                   (coverage_i >= cov_floor_q);
  assign size_ok = (32'(width_c) >= 32'(min_box_width_q));

  assign new_entry = {quality & size_ok,
                      CW'(left_c), CW'(top_c),
                      CW'(left_c) + CW'(width_c),
                      CW'(top_c) + CW'(height_c)};

  // ring of cells, appended at the head, rotated through the tail
  assign tail    = cell_q[WINDOW_MAX-1];
  assign cell0_d = append ? new_entry : tail;

  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
    cst_cell #(
      .ENTRY_W (ENTRY_W)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (append | walk),
      .d_i     ((j == 0) ? cell0_d : cell_q[(j == 0) ? 0 : j - 1]),
      .q_o     (cell_q[j])
    );
  end

  // tail position relative to the window
  assign fill_inc  = (LEN_W + 1)'(fill_q) + 1'b1;
  assign idx_inc   = (LEN_W + 1)'(idx_q) + 1'b1;
  assign in_window = (LEN_W'(idx_q) < len_eff);
  assign is_ref    = (idx_inc == (LEN_W + 1)'(len_eff));
  assign check     = (idx_inc < (LEN_W + 1)'(len_eff));

  // sequencer
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    drain_d       = drain_q;
    fail_d        = fail_q;
    ok_all_d      = ok_all_q;
    full_d        = full_q;
    fill_d        = fill_q;
    qual_d        = qual_q;
    size_d        = size_q;
    ref_d         = ref_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    out_qual_d    = out_qual_q;
    out_size_d    = out_size_q;
    out_stable_d  = out_stable_q;
    out_capture_d = out_capture_q;
    append        = 1'b0;
    walk          = 1'b0;
    dist_ctl      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          fail_d = 1'b0;
          if (region_found_i) begin
            append   = 1'b1;
            qual_d   = quality;
            size_d   = size_ok;
            ok_all_d = 1'b1;
            full_d   = (fill_inc >= (LEN_W + 1)'(len_eff));
            fill_d   = (fill_inc > (LEN_W + 1)'(len_eff)) ? len_eff : LEN_W'(fill_inc);
            idx_d    = IDX_W'(WINDOW_MAX - 1);
            state_d  = ST_WALK;
          end else begin
            // no region empties the window and clears every flag
            qual_d   = 1'b0;
            size_d   = 1'b0;
            ok_all_d = 1'b0;
            full_d   = 1'b0;
            fill_d   = '0;
            state_d  = ST_DONE;
          end
        end
      end
      ST_WALK: begin
        walk           = 1'b1;
        dist_ctl.valid = 1'b1;
        dist_ctl.check = check;
        if (in_window) begin
          ok_all_d = ok_all_q & tail[ENTRY_W-1];
        end
        if (is_ref) begin
          ref_d = tail[CORN_W-1:0];
        end
        if (idx_q == '0) begin
          drain_d = 1'b0;
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      ST_DRAIN: begin
        if (drain_q) begin
          state_d = ST_DONE;
        end else begin
          drain_d = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          out_qual_d    = qual_q;
          out_size_d    = size_q;
          out_stable_d  = full_q & ~fail_q;
          out_capture_d = full_q & ~fail_q & ok_all_q;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // any corner past the limit breaks stability
    if (dist_res.valid && dist_res.over) begin
      fail_d = 1'b1;
    end
  end

  // distance unit against the oldest entry
  cst_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (dist_ctl),
    .ent_i         (tail[CORN_W-1:0]),
    .ref_i         (ref_q),
    .move_lim_sq_i (move_lim_sq_q),
    .res_o         (dist_res)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      drain_q     <= 1'b0;
      fail_q      <= 1'b0;
      ok_all_q    <= 1'b0;
      full_q      <= 1'b0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      drain_q     <= drain_d;
      fail_q      <= fail_d;
      ok_all_q    <= ok_all_d;
      full_q      <= full_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    qual_q        <= qual_d;
    size_q        <= size_d;
    ref_q         <= ref_d;
    out_qual_q    <= out_qual_d;
    out_size_q    <= out_size_d;
    out_stable_q  <= out_stable_d;
    out_capture_q <= out_capture_d;
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign qual_pass_o    = out_qual_q;
  assign size_ok_o      = out_size_q;
  assign stable_o       = out_stable_q;
  assign capture_fire_o = out_capture_q;

  // a record without a region empties the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !region_found_i |=> fill_q == '0)
    else $error("window not emptied after a record without a region");

  // capture only ever comes with stability
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && capture_fire_o |-> stable_o)
    else $error("capture without stability");

  // distance verdicts arrive only while the window walk is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_res.valid |-> (state_q == ST_WALK) || (state_q == ST_DRAIN))
    else $error("distance verdict outside the window walk");

  // while the window is walked, it never holds more than the effective length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> fill_q <= len_eff)
    else $error("window fill beyond its length");

endmodule
